// ===== hw/rtl/mi44_pkg.sv =====
package mi44_pkg;

    // Element and stream widths
    localparam int ELEM_W    = 32;
    localparam int EPS_W     = 17;
    localparam int MAT_N     = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int FRAC_BITS = 16;

    // Wide intermediate values stay within +-(2^62 - 1)
    localparam int WIDE_W    = 63;
    localparam int MAG_W     = WIDE_W - 1;
    localparam int PROD_W    = ELEM_W + MAG_W;
    localparam int QUO_BITS  = 33;
    localparam int DIV_W     = MAG_W + QUO_BITS;
    localparam int DCNT_W    = 6;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    // Job handed from the load side to the compute side
    typedef struct packed {
        logic [EPS_W-1:0] eps;
    } cmd_t;

    // Where the second multiplier operand comes from
    typedef enum logic [1:0] {
        SRC_ELEM,
        SRC_T,
        SRC_COF
    } bsrc_t;

    // What the product does to the running sums
    typedef enum logic [2:0] {
        OP_T_LOAD,
        OP_T_SUB,
        OP_D_LOAD,
        OP_D_SUB,
        OP_D_ADD
    } acc_op_t;

    typedef enum logic {
        PH_COF,
        PH_DET
    } phase_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_RD,
        BK_M0,
        BK_M1,
        BK_M2,
        BK_RND,
        BK_ACC,
        BK_EM_RD,
        BK_DV_INIT,
        BK_DV_STEP,
        BK_DV_RND,
        BK_EM_OUT
    } bk_state_t;

    // One multiply-accumulate step of a 3x3 cofactor
    typedef struct packed {
        logic [1:0] ar;
        logic [1:0] ac;
        logic [1:0] br;
        logic [1:0] bc;
        bsrc_t      bsrc;
        acc_op_t    op;
    } step_t;

    // Pick the n-th row or column of the minor that leaves out x
    function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] n);
        return (n < x) ? n : n + 2'd1;
    endfunction

    // Minor expansion along its first row, nine products
    function automatic step_t cof_step(input logic [3:0] s);
        step_t r;
        unique case (s)
            4'd0:    r = '{2'd1, 2'd1, 2'd2, 2'd2, SRC_ELEM, OP_T_LOAD};
            4'd1:    r = '{2'd1, 2'd2, 2'd2, 2'd1, SRC_ELEM, OP_T_SUB};
            4'd2:    r = '{2'd0, 2'd0, 2'd0, 2'd0, SRC_T,    OP_D_LOAD};
            4'd3:    r = '{2'd1, 2'd0, 2'd2, 2'd2, SRC_ELEM, OP_T_LOAD};
            4'd4:    r = '{2'd1, 2'd2, 2'd2, 2'd0, SRC_ELEM, OP_T_SUB};
            4'd5:    r = '{2'd0, 2'd1, 2'd0, 2'd0, SRC_T,    OP_D_SUB};
            4'd6:    r = '{2'd1, 2'd0, 2'd2, 2'd1, SRC_ELEM, OP_T_LOAD};
            4'd7:    r = '{2'd1, 2'd1, 2'd2, 2'd0, SRC_ELEM, OP_T_SUB};
            4'd8:    r = '{2'd0, 2'd2, 2'd0, 2'd0, SRC_T,    OP_D_ADD};
            default: r = '{2'd0, 2'd0, 2'd0, 2'd0, SRC_ELEM, OP_T_LOAD};
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/mi44_ram.sv =====
module mi44_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one port, read two registered ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== hw/rtl/mi44_front.sv =====
module mi44_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mi44_pkg::ELEM_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    input  logic                         cfg_we,
    input  logic [mi44_pkg::EPS_W-1:0]   cfg_wdata,
    input  logic                         job_pending,
    output logic                         ram_we,
    output logic [mi44_pkg::IDX_W-1:0]   ram_waddr,
    output logic [mi44_pkg::ELEM_W-1:0]  ram_wdata,
    output logic                         cmd_push,
    output mi44_pkg::cmd_t               cmd
);
    import mi44_pkg::*;

    logic [CNT_W-1:0] load_count_reg;
    logic [EPS_W-1:0] eps_reg;
    logic             accept;

    // Hold off new elements while a matrix is outstanding
    assign s_tready  = !job_pending;
    assign accept    = s_tvalid && s_tready;
    assign ram_we    = accept && (load_count_reg < CNT_W'(MAT_N));
    assign ram_waddr = load_count_reg[IDX_W-1:0];
    assign ram_wdata = s_tdata;
    assign cmd_push  = accept && s_tlast;
    assign cmd.eps   = eps_reg;

    // Count loaded elements, restart on the last mark
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                load_count_reg <= '0;
            end else if (load_count_reg < CNT_W'(MAT_N)) begin
                load_count_reg <= load_count_reg + CNT_W'(1);
            end
        end
    end

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

endmodule

// ===== hw/rtl/mi44_queue.sv =====
module mi44_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mi44_pkg::cmd_t cmd_in,
    output logic           out_valid,
    output mi44_pkg::cmd_t cmd_out,
    input  logic           pop
);
    import mi44_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign out_valid = (count_reg != 2'd0);
    assign cmd_out   = slot_reg[rd_ptr_reg];

    // Store pushed jobs
    always_ff @(posedge aclk) begin
        if (push && count_reg != 2'd2) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && count_reg != 2'd2) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && out_valid) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            priority if ((push && count_reg != 2'd2) && !(pop && out_valid)) begin
                count_reg <= count_reg + 2'd1;
            end else if (!(push && count_reg != 2'd2) && (pop && out_valid)) begin
                count_reg <= count_reg - 2'd1;
            end else begin
                count_reg <= count_reg;
            end
        end
    end

endmodule

// ===== hw/rtl/mi44_back.sv =====
module mi44_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    input  mi44_pkg::cmd_t               cmd,
    output logic                         cmd_pop,
    output logic [mi44_pkg::IDX_W-1:0]   ram_raddr_a,
    output logic [mi44_pkg::IDX_W-1:0]   ram_raddr_b,
    input  logic [mi44_pkg::ELEM_W-1:0]  ram_rdata_a,
    input  logic [mi44_pkg::ELEM_W-1:0]  ram_rdata_b,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mi44_pkg::ELEM_W-1:0]  m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);
    import mi44_pkg::*;

    typedef struct packed {
        logic                     clip;
        logic signed [WIDE_W-1:0] val;
    } sat_t;

    localparam logic signed [WIDE_W:0] LIM_S =
        (WIDE_W+1)'((64'd1 << (WIDE_W-1)) - 64'd1);
    localparam logic [PROD_W:0] LIM_P =
        (PROD_W+1)'((64'd1 << (WIDE_W-1)) - 64'd1);
    localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << (FRAC_BITS-1);
    localparam logic [QUO_BITS:0] POS_MAX = (QUO_BITS+1)'(32'h7FFF_FFFF);
    localparam logic [QUO_BITS:0] NEG_MAX = (QUO_BITS+1)'(32'h8000_0000);

    // Saturating add of two wide values
    function automatic sat_t sat_add(input logic signed [WIDE_W-1:0] a,
                                     input logic signed [WIDE_W-1:0] b);
        logic signed [WIDE_W:0] s;
        sat_t r;
        s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        r.clip = 1'b0;
        r.val  = s[WIDE_W-1:0];
        if (s > LIM_S) begin
            r.clip = 1'b1;
            r.val  = LIM_S[WIDE_W-1:0];
        end else if (s < -LIM_S) begin
            r.clip = 1'b1;
            r.val  = -LIM_S[WIDE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] wmag(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] n;
        n = -v;
        return v[WIDE_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    bk_state_t state_reg, state_next;
    phase_t    phase_reg;

    logic [IDX_W-1:0]         cof_idx_reg;
    logic [3:0]               step_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic [ELEM_W-1:0]        a_mag_reg;
    logic [MAG_W-1:0]         b_mag_reg;
    logic                     neg_reg;
    logic [2*ELEM_W-1:0]      pp_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [WIDE_W-1:0] p_reg;
    logic signed [WIDE_W-1:0] t_reg;
    logic signed [WIDE_W-1:0] d_reg;
    logic                     clip_reg;
    logic signed [WIDE_W-1:0] cof_reg [MAT_N];
    logic [MAT_N-1:0]         cof_clip_reg;
    logic signed [WIDE_W-1:0] det_reg;
    logic                     det_clip_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         dsh_reg;
    logic [QUO_BITS-1:0]      q_reg;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic                     div_over_reg;
    logic                     div_neg_reg;
    logic [ELEM_W-1:0]        div_val_reg;
    logic                     div_clip_reg;
    logic                     m_valid_reg;
    logic [ELEM_W-1:0]        m_data_reg;
    logic [1:0]               m_user_reg;
    logic                     m_last_reg;

    step_t                    st;
    bsrc_t                    b_src;
    acc_op_t                  op;
    logic [1:0]               ci, cj;
    logic signed [WIDE_W-1:0] b_val;
    logic signed [ELEM_W-1:0] a_val;
    logic [ELEM_W-1:0]        a_neg;
    logic [ELEM_W-1:0]        mul_b;
    logic [2*ELEM_W-1:0]      mul_out;
    logic [PROD_W:0]          rsum, rsh;
    logic                     rclamp;
    logic [MAG_W-1:0]         rmag;
    logic signed [WIDE_W-1:0] acc_base, acc_rhs, t_new, d_new, cof_new;
    sat_t                     acc_sum;
    logic                     acc_clip;
    logic [MAG_W-1:0]         det_mag;
    logic                     sing;
    logic [IDX_W-1:0]         src;
    logic [DIV_W-1:0]         num, den_w;
    logic                     rnd_up;
    logic [QUO_BITS:0]        q2;
    logic                     q_clip;
    logic                     out_free;
    logic                     last_step;

    assign ci       = cof_idx_reg[3:2];
    assign cj       = cof_idx_reg[1:0];
    assign st       = cof_step(step_reg);
    assign det_mag  = wmag(det_reg);
    assign sing     = det_mag <= MAG_W'(cmd.eps);
    assign src      = {out_idx_reg[1:0], out_idx_reg[3:2]};
    assign out_free = !m_valid_reg || m_tready;
    assign last_step = (phase_reg == PH_COF) ? (step_reg == 4'd8) : (step_reg == 4'd3);

    // Share one 32x32 multiplier between the low and high operand halves
    assign mul_b   = (state_reg == BK_M2) ? {2'b00, b_mag_reg[MAG_W-1:ELEM_W]}
                                          : b_mag_reg[ELEM_W-1:0];
    assign mul_out = a_mag_reg * mul_b;

    // Decode the current step and the element addresses
    always_comb begin
        ram_raddr_a = out_idx_reg;
        ram_raddr_b = out_idx_reg;
        if (phase_reg == PH_COF) begin
            b_src = st.bsrc;
            op    = st.op;
            if (state_reg == BK_RD) begin
                ram_raddr_a = {skip_idx(ci, st.ar), skip_idx(cj, st.ac)};
                ram_raddr_b = {skip_idx(ci, st.br), skip_idx(cj, st.bc)};
            end
        end else begin
            b_src = SRC_COF;
            op    = (step_reg == 4'd0) ? OP_D_LOAD : OP_D_ADD;
            if (state_reg == BK_RD) begin
                ram_raddr_a = {2'd0, step_reg[1:0]};
            end
        end
    end

    // Operand fetch, rounding and accumulation
    always_comb begin
        a_val = ram_rdata_a;
        a_neg = -ram_rdata_a;
        unique case (b_src)
            SRC_ELEM: b_val = WIDE_W'(signed'(ram_rdata_b));
            SRC_T:    b_val = t_reg;
            SRC_COF:  b_val = cof_reg[{2'b00, step_reg[1:0]}];
            default:  b_val = t_reg;
        endcase

        rsum   = {1'b0, prod_reg} + RND_HALF;
        rsh    = rsum >> FRAC_BITS;
        rclamp = rsh > LIM_P;
        rmag   = rclamp ? LIM_P[MAG_W-1:0] : rsh[MAG_W-1:0];

        acc_base = (op == OP_T_SUB) ? t_reg : d_reg;
        acc_rhs  = (op == OP_T_SUB || op == OP_D_SUB) ? -p_reg : p_reg;
        acc_sum  = sat_add(acc_base, acc_rhs);
        t_new    = t_reg;
        d_new    = d_reg;
        acc_clip = 1'b0;
        unique case (op)
            OP_T_LOAD: t_new = p_reg;
            OP_T_SUB: begin
                t_new    = acc_sum.val;
                acc_clip = acc_sum.clip;
            end
            OP_D_LOAD: d_new = p_reg;
            OP_D_SUB, OP_D_ADD: begin
                d_new    = acc_sum.val;
                acc_clip = acc_sum.clip;
            end
            default: t_new = t_reg;
        endcase
        cof_new = (ci[0] ^ cj[0]) ? -d_new : d_new;

        num    = DIV_W'(wmag(cof_reg[src])) << FRAC_BITS;
        den_w  = DIV_W'(det_mag);
        rnd_up = {rem_reg, 1'b0} >= {1'b0, den_w};
        q2     = {1'b0, q_reg} + (QUO_BITS+1)'(rnd_up);
        q_clip = div_over_reg || (div_neg_reg ? (q2 > NEG_MAX) : (q2 > POS_MAX));
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            BK_IDLE:    if (cmd_valid) state_next = BK_RD;
            BK_RD:      state_next = BK_M0;
            BK_M0:      state_next = BK_M1;
            BK_M1:      state_next = BK_M2;
            BK_M2:      state_next = BK_RND;
            BK_RND:     state_next = BK_ACC;
            BK_ACC: begin
                if (phase_reg == PH_DET && last_step) begin
                    state_next = BK_EM_RD;
                end else begin
                    state_next = BK_RD;
                end
            end
            BK_EM_RD:   state_next = sing ? BK_EM_OUT : BK_DV_INIT;
            BK_DV_INIT: state_next = (num >= (den_w << QUO_BITS)) ? BK_DV_RND : BK_DV_STEP;
            BK_DV_STEP: if (div_cnt_reg == '0) state_next = BK_DV_RND;
            BK_DV_RND:  state_next = BK_EM_OUT;
            BK_EM_OUT: begin
                if (out_free) begin
                    if (out_idx_reg == IDX_W'(MAT_N-1)) begin
                        cmd_pop    = 1'b1;
                        state_next = BK_IDLE;
                    end else begin
                        state_next = BK_EM_RD;
                    end
                end
            end
            default:    state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Counters and phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_COF;
            cof_idx_reg <= '0;
            step_reg    <= '0;
            out_idx_reg <= '0;
        end else begin
            unique case (state_reg)
                BK_IDLE: begin
                    phase_reg   <= PH_COF;
                    cof_idx_reg <= '0;
                    step_reg    <= '0;
                    out_idx_reg <= '0;
                end
                BK_ACC: begin
                    if (!last_step) begin
                        step_reg <= step_reg + 4'd1;
                    end else begin
                        step_reg <= '0;
                        if (phase_reg == PH_COF) begin
                            if (cof_idx_reg == IDX_W'(MAT_N-1)) begin
                                phase_reg <= PH_DET;
                            end
                            cof_idx_reg <= cof_idx_reg + IDX_W'(1);
                        end
                    end
                end
                BK_EM_OUT: begin
                    if (out_free) begin
                        out_idx_reg <= out_idx_reg + IDX_W'(1);
                    end
                end
                default: begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    // Datapath: multiply, round, accumulate, divide
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            BK_IDLE: clip_reg <= 1'b0;
            BK_M0: begin
                a_mag_reg <= a_val[ELEM_W-1] ? a_neg : a_val;
                b_mag_reg <= wmag(b_val);
                neg_reg   <= a_val[ELEM_W-1] ^ b_val[WIDE_W-1];
            end
            BK_M1: pp_reg <= mul_out;
            BK_M2: prod_reg <= PROD_W'(pp_reg) + (PROD_W'(mul_out) << ELEM_W);
            BK_RND: begin
                p_reg    <= neg_reg ? -signed'({1'b0, rmag}) : signed'({1'b0, rmag});
                clip_reg <= clip_reg | rclamp;
            end
            BK_ACC: begin
                t_reg    <= t_new;
                d_reg    <= d_new;
                clip_reg <= clip_reg | acc_clip;
                if (last_step) begin
                    clip_reg <= 1'b0;
                    if (phase_reg == PH_COF) begin
                        cof_reg[cof_idx_reg]      <= cof_new;
                        cof_clip_reg[cof_idx_reg] <= clip_reg | acc_clip;
                    end else begin
                        det_reg      <= d_new;
                        det_clip_reg <= clip_reg | acc_clip;
                    end
                end
            end
            BK_DV_INIT: begin
                rem_reg      <= num;
                dsh_reg      <= den_w << (QUO_BITS-1);
                q_reg        <= '0;
                div_cnt_reg  <= DCNT_W'(QUO_BITS-1);
                div_over_reg <= num >= (den_w << QUO_BITS);
                div_neg_reg  <= cof_reg[src][WIDE_W-1] ^ det_reg[WIDE_W-1];
            end
            BK_DV_STEP: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[QUO_BITS-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[QUO_BITS-2:0], 1'b0};
                end
                dsh_reg     <= dsh_reg >> 1;
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end
            BK_DV_RND: begin
                div_clip_reg <= q_clip;
                if (q_clip) begin
                    div_val_reg <= div_neg_reg ? NEG_MAX[ELEM_W-1:0] : POS_MAX[ELEM_W-1:0];
                end else begin
                    div_val_reg <= div_neg_reg ? -q2[ELEM_W-1:0] : q2[ELEM_W-1:0];
                end
            end
            default: begin
                pp_reg <= pp_reg;
            end
        endcase
    end

    // Output register; the next result is prepared while this one waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == BK_EM_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_EM_OUT && out_free) begin
            m_data_reg <= sing ? ram_rdata_a : div_val_reg;
            m_user_reg <= {(!sing) && (div_clip_reg || cof_clip_reg[src] || det_clip_reg),
                           sing};
            m_last_reg <= (out_idx_reg == IDX_W'(MAT_N-1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hw/rtl/matrix_inverse_4x4_core.sv =====
// 4x4 matrix inverse, signed Q16.16, adjugate method.
// Input stream: sixteen elements in row-major order on s_tdata, s_tlast on
// the sixteenth. Each element takes one cycle. After the last mark the
// input stays stalled until the last result of that matrix has entered the
// output register.
// Output stream: sixteen results in row-major order, m_tlast on the last;
// m_tuser carries the singular and saturated flags.
// The cofactor pass runs 16 x 9 multiply steps and the determinant 4 more,
// each through the states RD, M0, M1, M2, RND and ACC on one 32x32
// multiplier. Each result then passes the bit-serial divider (33 quotient
// bits), or goes straight to output when the matrix is singular.
// cfg_we/cfg_wdata write the singular threshold; write it only when idle.
// Reset (aresetn low, synchronous) clears the load count, sets the
// threshold to 1 and drops any pending matrix. When m_tready is low the
// finished result holds in the output register and the sequencer waits.
module matrix_inverse_4x4_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mi44_pkg::ELEM_W-1:0]  s_tdata,   // element_value
    input  logic                         s_tlast,   // is_last_element
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mi44_pkg::ELEM_W-1:0]  m_tdata,   // result_value
    output logic [1:0]                   m_tuser,   // [0] singular, [1] saturated
    output logic                         m_tlast,   // last_result
    input  logic                         cfg_we,
    input  logic [mi44_pkg::EPS_W-1:0]   cfg_wdata
);
    import mi44_pkg::*;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [ELEM_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;
    logic              cmd_push, cmd_valid, cmd_pop;
    cmd_t              cmd_in, cmd_out;

    mi44_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .job_pending (cmd_valid),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    mi44_ram #(.WIDTH(ELEM_W), .DEPTH(MAT_N)) u_store (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_addr_a (ram_raddr_a),
        .rd_addr_b (ram_raddr_b),
        .rd_data_a (ram_rdata_a),
        .rd_data_b (ram_rdata_b)
    );

    mi44_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .cmd_in    (cmd_in),
        .out_valid (cmd_valid),
        .cmd_out   (cmd_out),
        .pop       (cmd_pop)
    );

    mi44_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd_out),
        .cmd_pop     (cmd_pop),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== hw/rtl/mi44_checker.sv =====
module mi44_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mi44_pkg::ELEM_W-1:0]  m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tlast
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // A singular matrix never reports saturation
    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("singular result flagged saturated");

    // An accepted last element drops s_tready
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after last element");

    // No result straight out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind matrix_inverse_4x4_core mi44_checker u_chk (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mi44_pkg::*;

    localparam longint WIDE_LIM = 64'sd4611686018427387903;
    localparam int     RAND_ITEMS = 200;

    typedef struct {
        logic [ELEM_W-1:0] value;
        logic              singular;
        logic              saturated;
        logic              last;
    } inv_result_t;

    typedef struct {
        logic [ELEM_W-1:0] value;
        logic              last;
    } elem_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [ELEM_W-1:0] s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [ELEM_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_we = 1'b0;
    logic [EPS_W-1:0]  cfg_wdata = '0;

    // Model state of the block
    longint            mat_mirror [16];
    int                fill_count;
    logic [EPS_W-1:0]  eps_mirror;
    bit                clip_hit;

    inv_result_t       pending_results [$];
    inv_result_t       hand_results [$];
    int                error_count;
    bit                hold_off_req;
    bit                calm;

    matrix_inverse_4x4_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Fixed-point product, rounded half away from zero, clipped to the wide bound
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0]     p;
        longint unsigned  ua;
        longint unsigned  ub;
        bit               neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (p > 128'(WIDE_LIM)) begin
            clip_hit = 1'b1;
            p = 128'(WIDE_LIM);
        end
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint fx_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > WIDE_LIM) begin
            clip_hit = 1'b1;
            return WIDE_LIM;
        end
        if (s < -WIDE_LIM) begin
            clip_hit = 1'b1;
            return -WIDE_LIM;
        end
        return s;
    endfunction

    function automatic longint at(int r, int c);
        return mat_mirror[r * 4 + c];
    endfunction

    // Signed 3x3 minor, expanded along its first row
    function automatic longint signed_minor(int i, int j);
        int     rs [3];
        int     cs [3];
        int     nr;
        int     nc;
        longint d;
        longint t;
        nr = 0;
        nc = 0;
        for (int k = 0; k < 4; k++) begin
            if (k != i) begin
                rs[nr] = k;
                nr++;
            end
            if (k != j) begin
                cs[nc] = k;
                nc++;
            end
        end
        t = fx_add(fx_mul(at(rs[1], cs[1]), at(rs[2], cs[2])),
                   -fx_mul(at(rs[1], cs[2]), at(rs[2], cs[1])));
        d = fx_mul(at(rs[0], cs[0]), t);
        t = fx_add(fx_mul(at(rs[1], cs[0]), at(rs[2], cs[2])),
                   -fx_mul(at(rs[1], cs[2]), at(rs[2], cs[0])));
        d = fx_add(d, -fx_mul(at(rs[0], cs[1]), t));
        t = fx_add(fx_mul(at(rs[1], cs[0]), at(rs[2], cs[1])),
                   -fx_mul(at(rs[1], cs[1]), at(rs[2], cs[0])));
        d = fx_add(d, fx_mul(at(rs[0], cs[2]), t));
        return ((i + j) % 2) ? -d : d;
    endfunction

    // Rounded quotient, saturated to 32 bits
    function automatic logic [ELEM_W-1:0] fx_div(longint num, longint den, inout bit clip);
        logic [127:0]    n;
        logic [127:0]    q;
        logic [127:0]    r;
        longint unsigned un;
        longint unsigned ud;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        n = {64'd0, un} << FRAC_BITS;
        q = n / ud;
        r = n % ud;
        if (q < (128'd1 << 42) && 2 * r >= ud)
            q++;
        if ((num < 0) != (den < 0)) begin
            if (q > 128'h8000_0000) begin
                clip = 1'b1;
                return 32'h8000_0000;
            end
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) begin
            clip = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    // Load one element; on a last mark queue the sixteen inverse items
    function automatic void load_and_invert(logic [ELEM_W-1:0] v, logic last);
        longint      cof [16];
        bit          cof_clip [16];
        longint      det;
        bit          det_clip;
        bit          sing;
        bit          clip;
        int          src;
        inv_result_t res;
        if (fill_count < 16) begin
            mat_mirror[fill_count] = longint'(signed'(v));
            fill_count++;
        end
        if (!last)
            return;
        fill_count = 0;
        for (int k = 0; k < 16; k++) begin
            clip_hit = 1'b0;
            cof[k] = signed_minor(k / 4, k % 4);
            cof_clip[k] = clip_hit;
        end
        clip_hit = 1'b0;
        det = 0;
        for (int k = 0; k < 4; k++)
            det = fx_add(det, fx_mul(at(0, k), cof[k]));
        det_clip = clip_hit;
        sing = ((det < 0) ? -det : det) <= longint'(eps_mirror);
        for (int k = 0; k < 16; k++) begin
            if (sing) begin
                res.value = mat_mirror[k][31:0];
                res.saturated = 1'b0;
            end else begin
                clip = det_clip;
                src = (k % 4) * 4 + k / 4;
                res.value = fx_div(cof[src], det, clip);
                res.saturated = clip || cof_clip[src];
            end
            res.singular = sing;
            res.last = (k == 15);
            if (hand_results.size() == 0)
                pending_results.push_back(res);
        end
        // Hand-typed expectations replace the computed ones for this matrix
        while (hand_results.size() > 0)
            pending_results.push_back(hand_results.pop_front());
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Track accepted items and check results
    always @(posedge aclk) begin
        inv_result_t exp_res;
        if (aresetn && s_tvalid && s_tready)
            load_and_invert(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item %h", m_tdata);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata !== exp_res.value) begin
                    $error("result_value exp %h got %h", exp_res.value, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== exp_res.singular) begin
                    $error("singular exp %b got %b", exp_res.singular, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== exp_res.saturated) begin
                    $error("saturated exp %b got %b", exp_res.saturated, m_tuser[1]);
                    error_count++;
                end
                if (m_tlast !== exp_res.last) begin
                    $error("last_result exp %b got %b", exp_res.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (3000) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(negedge aclk);
        end
    end

    task automatic send_elem(logic [ELEM_W-1:0] v, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Write the threshold once the block has drained
    task automatic set_threshold(logic [EPS_W-1:0] eps);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= eps;
        eps_mirror = eps;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [ELEM_W-1:0] rand_elem(int kind);
        case (kind)
            5:       return $urandom();
            7:       return ELEM_W'($signed($urandom_range(0, 32'h7FFF)) - 32'sh4000);
            default: return ELEM_W'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
        endcase
    endfunction

    initial begin
        elem_row_t         directed [$];
        logic [ELEM_W-1:0] m [16];
        inv_result_t       hr;
        int                kind;
        int                len;
        int                sent;
        int                mat_no;
        logic [EPS_W-1:0]  eps_list [4];

        error_count = 0;
        fill_count = 0;
        eps_mirror = EPS_RESET;
        hold_off_req = 1'b0;
        calm = 1'b0;
        for (int k = 0; k < 16; k++)
            mat_mirror[k] = 0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Identity in, identity out
        for (int k = 0; k < 16; k++) begin
            directed.push_back('{(k % 5 == 0) ? 32'h0001_0000 : 32'h0, k == 15});
            hr.value = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;
            hr.singular = 1'b0;
            hr.saturated = 1'b0;
            hr.last = (k == 15);
            hand_results.push_back(hr);
        end
        // Early last mark over extreme values, rest of the store kept
        directed.push_back('{32'h8000_0000, 1'b0});
        directed.push_back('{32'h7FFF_FFFF, 1'b0});
        directed.push_back('{32'hFFFF_FFFF, 1'b0});
        directed.push_back('{32'h0000_0001, 1'b1});
        foreach (directed[i])
            send_elem(directed[i].value, directed[i].last);

        eps_list = '{17'd0, 17'd65536, 17'd1, 17'd0};
        sent = 0;
        mat_no = 0;
        while (sent < RAND_ITEMS) begin
            if (mat_no % 4 == 3)
                set_threshold((mat_no / 4 == 2) ? EPS_W'($urandom_range(0, 65536))
                                                 : eps_list[(mat_no / 4) % 4]);
            if (mat_no == 2)
                hold_off_req = 1'b1;
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 16; k++)
                m[k] = rand_elem(kind);
            // Duplicate row gives an exactly singular matrix
            if (kind == 6)
                for (int c = 0; c < 4; c++)
                    m[4 + c] = m[c];
            len = 16;
            if (kind == 8)
                len = $urandom_range(1, 15);
            else if (kind == 9)
                len = $urandom_range(17, 20);
            for (int k = 0; k < len; k++)
                send_elem((k < 16) ? m[k] : ELEM_W'($urandom()), k == len - 1);
            sent += len;
            mat_no++;
        end
        s_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
